// ----- rtl/core/pfr_pkg.sv -----
package pfr_pkg;

   localparam int FRAMES     = 8;
   localparam int PAGE_W     = 16;
   localparam int TIME_W     = 32;
   localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W      = $clog2(FRAMES + 1);
   localparam int FIU_W      = 7;
   localparam int OUT_IDX_W  = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = 1'd1;

   localparam logic MODE_LRU = 1'b0;
   localparam logic MODE_LFU = 1'b1;

   localparam logic [FIU_W-1:0]  FIU_RESET = 7'd8;
   localparam logic [TIME_W-1:0] TIME_MAX  = '1;

   typedef logic [IDX_W-1:0]  frame_idx_type;
   typedef logic [PAGE_W-1:0] page_type;
   typedef logic [TIME_W-1:0] stamp_type;

   typedef struct packed {
      page_type  page;
      stamp_type use_time;
      stamp_type use_count;
   } frame_entry_type;

   typedef struct packed {
      logic            rd_en;
      frame_idx_type   rd_addr;
      logic            wr_en;
      frame_idx_type   wr_addr;
      frame_entry_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic            clear;
      logic            vld;
      frame_idx_type   idx;
      logic            occupied;
      frame_entry_type entry;
   } scan_probe_type;

   typedef struct packed {
      logic          hit;
      frame_idx_type hit_idx;
      stamp_type     hit_count;
      logic          empty_found;
      frame_idx_type empty_idx;
      frame_idx_type victim_idx;
   } scan_result_type;

endpackage

// ----- rtl/core/pfr_frame_mem.sv -----
module pfr_frame_mem
   import pfr_pkg::*;
(
   input  logic            clock,
   input  mem_req_type     mem_req,
   output frame_entry_type rd_data
);

   frame_entry_type mem [FRAMES];
   frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pfr_select.sv -----
module pfr_select
   import pfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            policy_mode,
   input  page_type        page,
   input  scan_probe_type  probe,
   output scan_result_type result
);

   logic          hit_ff, hit_in;
   frame_idx_type hit_idx_ff, hit_idx_in;
   stamp_type     hit_count_ff, hit_count_in;
   logic          empty_found_ff, empty_found_in;
   frame_idx_type empty_idx_ff, empty_idx_in;
   frame_idx_type victim_idx_ff, victim_idx_in;
   stamp_type     victim_time_ff, victim_time_in;
   stamp_type     victim_count_ff, victim_count_in;

   frame_entry_type entry;
   logic            better;

   always_comb begin
      entry = probe.occupied ? probe.entry : '0;
      if (policy_mode == MODE_LRU) begin
         better = entry.use_time < victim_time_ff;
      end else begin
         better = (entry.use_count < victim_count_ff) ||
                  ((entry.use_count == victim_count_ff) && (entry.use_time < victim_time_ff));
      end
   end

   always_comb begin
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_count_in    = hit_count_ff;
      empty_found_in  = empty_found_ff;
      empty_idx_in    = empty_idx_ff;
      victim_idx_in   = victim_idx_ff;
      victim_time_in  = victim_time_ff;
      victim_count_in = victim_count_ff;
      if (probe.clear) begin
         hit_in         = 1'b0;
         empty_found_in = 1'b0;
      end else if (probe.vld) begin
         if (!hit_ff && probe.occupied && (entry.page == page)) begin
            hit_in       = 1'b1;
            hit_idx_in   = probe.idx;
            hit_count_in = entry.use_count;
         end
         if (!empty_found_ff && !probe.occupied) begin
            empty_found_in = 1'b1;
            empty_idx_in   = probe.idx;
         end
         if ((probe.idx == '0) || better) begin
            victim_idx_in   = probe.idx;
            victim_time_in  = entry.use_time;
            victim_count_in = entry.use_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff         <= 1'b0;
         empty_found_ff <= 1'b0;
      end else begin
         hit_ff         <= hit_in;
         empty_found_ff <= empty_found_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff      <= hit_idx_in;
      hit_count_ff    <= hit_count_in;
      empty_idx_ff    <= empty_idx_in;
      victim_idx_ff   <= victim_idx_in;
      victim_time_ff  <= victim_time_in;
      victim_count_ff <= victim_count_in;
   end

   assign result.hit         = hit_ff;
   assign result.hit_idx     = hit_idx_ff;
   assign result.hit_count   = hit_count_ff;
   assign result.empty_found = empty_found_ff;
   assign result.empty_idx   = empty_idx_ff;
   assign result.victim_idx  = victim_idx_ff;

endmodule

// ----- rtl/core/pfr_ctrl.sv -----
module pfr_ctrl
   import pfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PAGE_W-1:0]     req_page_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_IDX_W-1:0]  rsp_frame_index,
   output logic [PAGE_W-1:0]     rsp_frame_page,
   output logic                  rsp_frame_occupied,
   output logic                  rsp_was_hit,
   output logic                  rsp_last_frame,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output mem_req_type           mem_req,
   input  frame_entry_type       rd_data,
   output logic                  policy_mode,
   output page_type              page,
   output scan_probe_type        probe,
   input  scan_result_type       result
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   logic [2:0]       state_ff, state_in;
   frame_idx_type    ptr_ff, ptr_in;
   logic             mode_ff;
   logic [FIU_W-1:0] fiu_ff;
   stamp_type        ref_time_ff, ref_time_in;
   logic [FRAMES-1:0] valid_ff, valid_in;
   page_type         page_ff;
   logic             hit_ff, hit_in;
   logic             rd_scan_ff, rd_rep_ff;
   frame_idx_type    rd_idx_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_index_ff;
   page_type             rsp_page_ff;
   logic                 rsp_occ_ff, rsp_hit_ff, rsp_last_ff;

   logic [CNT_W-1:0] act_cnt;
   frame_idx_type    last_idx;
   logic             accept_req, rsp_take, scan_issue, rep_issue, rd_occupied;
   frame_idx_type    slot;
   frame_entry_type  new_entry;

   always_comb begin
      if (fiu_ff == '0) begin
         act_cnt = CNT_W'(1);
      end else if (fiu_ff > FIU_W'(FRAMES)) begin
         act_cnt = CNT_W'(FRAMES);
      end else begin
         act_cnt = fiu_ff[CNT_W-1:0];
      end
      last_idx = IDX_W'(act_cnt - CNT_W'(1));
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept_req  = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign scan_issue  = (state_ff == ST_SCAN);
   assign rep_issue   = (state_ff == ST_REPORT) && !rd_rep_ff && (!rsp_valid_ff || rsp_take);
   assign rd_occupied = valid_ff[rd_idx_ff];

   always_comb begin
      if (result.hit) begin
         slot = result.hit_idx;
      end else if (result.empty_found) begin
         slot = result.empty_idx;
      end else begin
         slot = result.victim_idx;
      end
      new_entry.page     = page_ff;
      new_entry.use_time = ref_time_ff;
      if (!result.hit) begin
         new_entry.use_count = TIME_W'(1);
      end else if ((mode_ff == MODE_LFU) && (result.hit_count != TIME_MAX)) begin
         new_entry.use_count = result.hit_count + TIME_W'(1);
      end else begin
         new_entry.use_count = result.hit_count;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      ref_time_in = ref_time_ff;
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               state_in = ST_SCAN;
               ptr_in   = '0;
            end
         end
         ST_SCAN: begin
            if (ptr_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            valid_in[slot] = 1'b1;
            hit_in         = result.hit;
            if (ref_time_ff != TIME_MAX) begin
               ref_time_in = ref_time_ff + TIME_W'(1);
            end
            ptr_in   = '0;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (rep_issue) begin
               if (ptr_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_rep_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         mode_ff      <= MODE_LRU;
         fiu_ff       <= FIU_RESET;
         ref_time_ff  <= '0;
         valid_ff     <= '0;
         hit_ff       <= 1'b0;
         rd_scan_ff   <= 1'b0;
         rd_rep_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         ref_time_ff  <= ref_time_in;
         valid_ff     <= valid_in;
         hit_ff       <= hit_in;
         rd_scan_ff   <= scan_issue;
         rd_rep_ff    <= rep_issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_POLICY_MODE:   mode_ff <= csr_write_data[0];
               CSR_FRAMES_IN_USE: fiu_ff  <= csr_write_data[FIU_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= ptr_ff;
      if (accept_req) begin
         page_ff <= req_page_number;
      end
      if (rd_rep_ff) begin
         rsp_index_ff <= OUT_IDX_W'(rd_idx_ff);
         rsp_page_ff  <= rd_occupied ? rd_data.page : '0;
         rsp_occ_ff   <= rd_occupied;
         rsp_hit_ff   <= hit_ff;
         rsp_last_ff  <= (rd_idx_ff == last_idx);
      end
   end

   assign mem_req.rd_en   = scan_issue || rep_issue;
   assign mem_req.rd_addr = ptr_ff;
   assign mem_req.wr_en   = (state_ff == ST_UPDATE);
   assign mem_req.wr_addr = slot;
   assign mem_req.wr_data = new_entry;

   assign probe.clear    = accept_req;
   assign probe.vld      = rd_scan_ff;
   assign probe.idx      = rd_idx_ff;
   assign probe.occupied = rd_occupied;
   assign probe.entry    = rd_data;

   assign policy_mode = mode_ff;
   assign page        = page_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_index    = rsp_index_ff;
   assign rsp_frame_page     = rsp_page_ff;
   assign rsp_frame_occupied = rsp_occ_ff;
   assign rsp_was_hit        = rsp_hit_ff;
   assign rsp_last_frame     = rsp_last_ff;

endmodule

// ----- rtl/core/page_frame_replacement_lru_lfu_top.sv -----
// Page frame replacement over a fully associative set of frames, LRU or LFU as
// selected by policy_mode. Each request transaction carries one page reference; the
// block answers with one response transaction per active frame, in frame order, carrying
// the frame's page and occupancy after the reference, the hit flag of the reference
// and a marker on the last active frame. The active frames are frames_in_use, clamped
// to 1..8. A reference first sweeps the frame table through its single read port and
// writes back the updated entry, then reads each active frame again for the report and
// registers it as a response. Per-frame valid bits reset at once, so there is no
// clearing pass after reset. Write configuration only while the block is idle.
module page_frame_replacement_lru_lfu_top
   import pfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PAGE_W-1:0]     req_page_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_IDX_W-1:0]  rsp_frame_index,
   output logic [PAGE_W-1:0]     rsp_frame_page,
   output logic                  rsp_frame_occupied,
   output logic                  rsp_was_hit,
   output logic                  rsp_last_frame,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   mem_req_type     mem_req;
   frame_entry_type rd_data;
   logic            policy_mode;
   page_type        page;
   scan_probe_type  probe;
   scan_result_type result;

   pfr_frame_mem u_frame_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   pfr_select u_select (
      .clock       (clock),
      .reset       (reset),
      .policy_mode (policy_mode),
      .page        (page),
      .probe       (probe),
      .result      (result)
   );

   pfr_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_page_number    (req_page_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_frame_page     (rsp_frame_page),
      .rsp_frame_occupied (rsp_frame_occupied),
      .rsp_was_hit        (rsp_was_hit),
      .rsp_last_frame     (rsp_last_frame),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mem_req            (mem_req),
      .rd_data            (rd_data),
      .policy_mode        (policy_mode),
      .page               (page),
      .probe              (probe),
      .result             (result)
   );

endmodule

// ----- rtl/core/pfr_checker.sv -----
module pfr_checker
   import pfr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OUT_IDX_W-1:0] rsp_frame_index,
   input logic [PAGE_W-1:0]    rsp_frame_page,
   input logic                 rsp_frame_occupied,
   input logic                 rsp_last_frame
);

   logic rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_frame_index) && $stable(rsp_frame_page))
      else $error("stalled response changed");

   a_empty_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_occupied |-> rsp_frame_page == '0)
      else $error("empty frame reports a page");

   a_first_frame_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_index == '0) |-> rsp_frame_occupied)
      else $error("frame zero empty after a reference");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_take && !rsp_last_frame) && rsp_valid |->
         rsp_frame_index == $past(rsp_frame_index) + OUT_IDX_W'(1))
      else $error("frame index out of order");

   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_take && rsp_last_frame) && rsp_valid |-> rsp_frame_index == '0)
      else $error("report does not start at frame zero");

endmodule

bind page_frame_replacement_lru_lfu_top pfr_checker u_pfr_checker (.*);
